[hdl/kmap_pkg.sv]
package kmap_pkg;

   // Map geometry and sizes of the grouping search.
   localparam int CELLS      = 16;
   localparam int MAX_GROUPS = 16;
   localparam int CAND_COUNT = 104;

   // First index of each candidate family in the fixed search order.
   localparam int CAND_COLPAIR = 16;
   localparam int CAND_SQUARE  = 32;
   localparam int CAND_ROW     = 48;
   localparam int CAND_COL     = 52;
   localparam int CAND_HPAIR   = 56;
   localparam int CAND_VPAIR   = 72;
   localparam int CAND_SINGLE  = 88;

   // Literal codes of one variable in a product term.
   localparam logic [1:0] LIT_NEG    = 2'd0;
   localparam logic [1:0] LIT_POS    = 2'd1;
   localparam logic [1:0] LIT_ABSENT = 2'd2;

   typedef logic [6:0] cand_idx_type;
   typedef logic [3:0] group_idx_type;
   typedef logic [4:0] group_cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_MARK,
      ST_EMIT
   } state_type;

   // One candidate group: its cells and the literals of its product term.
   typedef struct packed {
      logic [15:0] mask;
      logic [1:0]  lit_a;
      logic [1:0]  lit_b;
      logic [1:0]  lit_c;
      logic [1:0]  lit_d;
   } cand_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic try_cand;
      logic mark;
      logic emit_term;
      logic emit_const;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic map_full;
      logic map_zero;
      logic cand_last;
      logic pend_empty;
      logic pend_single;
   } status_type;

   function automatic logic [15:0] row_mask(input logic [1:0] r);
      return 16'h000F << {r, 2'b00};
   endfunction

   function automatic logic [15:0] col_mask(input logic [1:0] c);
      return 16'h1111 << c;
   endfunction

   function automatic logic [15:0] cell_bit(input logic [1:0] r, input logic [1:0] c);
      return 16'h0001 << {r, c};
   endfunction

   // Literals of two adjacent Gray-ordered lines ending at line k: {hi, lo}.
   function automatic logic [3:0] pair_lits(input logic [1:0] k);
      logic [3:0] l;
      unique case (k)
         2'd1:    l = {LIT_NEG, LIT_ABSENT};
         2'd3:    l = {LIT_POS, LIT_ABSENT};
         2'd0:    l = {LIT_ABSENT, LIT_NEG};
         default: l = {LIT_ABSENT, LIT_POS};
      endcase
      return l;
   endfunction

   // Literals of a single Gray-ordered line k: {hi, lo}.
   function automatic logic [3:0] one_lits(input logic [1:0] k);
      return {1'b0, k[1], 1'b0, k[1] ^ k[0]};
   endfunction

   // Candidate group at a given position of the search order.
   function automatic cand_type cand_info(input cand_idx_type idx);
      cand_type   c;
      logic [6:0] k;
      logic [1:0] i;
      logic [1:0] j;
      logic [3:0] rl;
      logic [3:0] cl;
      c  = '0;
      k  = '0;
      rl = {LIT_ABSENT, LIT_ABSENT};
      cl = {LIT_ABSENT, LIT_ABSENT};
      if (idx < 7'(CAND_COLPAIR)) begin
         k = idx;
         i = k[3:2];
         c.mask = row_mask(i) | row_mask(i - 2'd1);
         rl = pair_lits(i);
      end else if (idx < 7'(CAND_SQUARE)) begin
         k = idx - 7'(CAND_COLPAIR);
         j = k[3:2];
         c.mask = col_mask(j) | col_mask(j - 2'd1);
         cl = pair_lits(j);
      end else if (idx < 7'(CAND_ROW)) begin
         k = idx - 7'(CAND_SQUARE);
         i = k[3:2];
         j = k[1:0];
         c.mask = cell_bit(i, j) | cell_bit(i - 2'd1, j) |
                  cell_bit(i, j - 2'd1) | cell_bit(i - 2'd1, j - 2'd1);
         rl = pair_lits(i);
         cl = pair_lits(j);
      end else if (idx < 7'(CAND_COL)) begin
         k = idx - 7'(CAND_ROW);
         i = k[1:0];
         c.mask = row_mask(i);
         rl = one_lits(i);
      end else if (idx < 7'(CAND_HPAIR)) begin
         k = idx - 7'(CAND_COL);
         j = k[1:0];
         c.mask = col_mask(j);
         cl = one_lits(j);
      end else if (idx < 7'(CAND_VPAIR)) begin
         k = idx - 7'(CAND_HPAIR);
         i = k[3:2];
         j = k[1:0];
         c.mask = cell_bit(i, j) | cell_bit(i, j - 2'd1);
         rl = one_lits(i);
         cl = pair_lits(j);
      end else if (idx < 7'(CAND_SINGLE)) begin
         // Vertical pairs run with the column as the outer index.
         k = idx - 7'(CAND_VPAIR);
         j = k[3:2];
         i = k[1:0];
         c.mask = cell_bit(i, j) | cell_bit(i - 2'd1, j);
         rl = pair_lits(i);
         cl = one_lits(j);
      end else if (idx < 7'(CAND_COUNT)) begin
         k = idx - 7'(CAND_SINGLE);
         i = k[3:2];
         j = k[1:0];
         c.mask = cell_bit(i, j);
         rl = one_lits(i);
         cl = one_lits(j);
      end
      c.lit_a = rl[3:2];
      c.lit_b = rl[1:0];
      c.lit_c = cl[3:2];
      c.lit_d = cl[1:0];
      return c;
   endfunction

endpackage

[hdl/kmap_ctrl.sv]
module kmap_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  kmap_pkg::status_type status,
   output kmap_pkg::cmd_type    cmd
);

   kmap_pkg::state_type state_ff;
   kmap_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmap_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         kmap_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = kmap_pkg::ST_SWEEP;
            end
         end
         kmap_pkg::ST_SWEEP: begin
            // Constant maps answer at once; others walk every candidate.
            if (status.map_full || status.map_zero) begin
               cmd.emit_const = 1'b1;
               state_in       = kmap_pkg::ST_IDLE;
            end else begin
               cmd.try_cand = 1'b1;
               if (status.cand_last) begin
                  state_in = kmap_pkg::ST_MARK;
               end
            end
         end
         kmap_pkg::ST_MARK: begin
            cmd.mark = 1'b1;
            state_in = kmap_pkg::ST_EMIT;
         end
         kmap_pkg::ST_EMIT: begin
            if (status.pend_empty) begin
               cmd.emit_const = 1'b1;
               state_in       = kmap_pkg::ST_IDLE;
            end else begin
               cmd.emit_term = 1'b1;
               if (status.pend_single) begin
                  state_in = kmap_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = kmap_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != kmap_pkg::ST_IDLE);

endmodule

[hdl/kmap_dpath.sv]
module kmap_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          req_cell_map,
   input  kmap_pkg::cmd_type    cmd,
   output kmap_pkg::status_type status,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_lit_a,
   output logic [1:0]           rsp_lit_b,
   output logic [1:0]           rsp_lit_c,
   output logic [1:0]           rsp_lit_d,
   output logic                 rsp_no_terms,
   output logic                 rsp_last_term
);

   logic [15:0]             map_ff;
   logic [15:0]             map_in;
   kmap_pkg::cand_idx_type  cidx_ff;
   kmap_pkg::cand_idx_type  cidx_in;
   logic [15:0]             cov_ff;
   logic [15:0]             cov_in;
   logic [15:0]             multi_ff;
   logic [15:0]             multi_in;
   kmap_pkg::group_cnt_type ngrp_ff;
   kmap_pkg::group_cnt_type ngrp_in;
   logic [15:0]             pend_ff;
   logic [15:0]             pend_in;
   logic [15:0]             gmask_ff [kmap_pkg::MAX_GROUPS];
   logic [7:0]              glit_ff  [kmap_pkg::MAX_GROUPS];

   kmap_pkg::cand_type      cand;
   logic                    take;
   logic [15:0]             ones;
   logic [15:0]             keep;
   kmap_pkg::group_idx_type pick;

   logic                    valid_ff;
   logic                    valid_in;
   logic [7:0]              lits_ff;
   logic [7:0]              lits_in;
   logic                    none_ff;
   logic                    none_in;
   logic                    last_ff;
   logic                    last_in;

   // Current candidate; it is taken when all its cells are set in the map,
   // one of them is still uncovered, and the group store has room.
   assign cand = kmap_pkg::cand_info(cidx_ff);
   assign take = cmd.try_cand &&
                 ((map_ff & cand.mask) == cand.mask) &&
                 ((cov_ff & cand.mask) != cand.mask) &&
                 !ngrp_ff[4];

   // Cells held by exactly one taken group.
   assign ones = cov_ff & ~multi_ff;

   // A taken group is kept when one of its cells belongs to it alone.
   always_comb begin
      for (int g = 0; g < kmap_pkg::MAX_GROUPS; g++) begin
         keep[g] = (5'(g) < ngrp_ff) && ((gmask_ff[g] & ones) != 16'd0);
      end
   end

   // Lowest pending group is the next one to emit.
   always_comb begin
      pick = '0;
      for (int g = kmap_pkg::MAX_GROUPS - 1; g >= 0; g--) begin
         if (pend_ff[g]) begin
            pick = 4'(g);
         end
      end
   end

   // Next values of the search and coverage registers.
   always_comb begin
      map_in   = map_ff;
      cidx_in  = cidx_ff;
      cov_in   = cov_ff;
      multi_in = multi_ff;
      ngrp_in  = ngrp_ff;
      pend_in  = pend_ff;
      if (cmd.load) begin
         map_in   = req_cell_map;
         cidx_in  = '0;
         cov_in   = '0;
         multi_in = '0;
         ngrp_in  = '0;
      end
      if (cmd.try_cand) begin
         cidx_in = cidx_ff + 7'd1;
      end
      if (take) begin
         // Coverage counts saturate at two: only zero, one and more matter.
         multi_in = multi_ff | (cov_ff & cand.mask);
         cov_in   = cov_ff | cand.mask;
         ngrp_in  = ngrp_ff + 5'd1;
      end
      if (cmd.mark) begin
         pend_in = keep;
      end
      if (cmd.emit_term) begin
         pend_in = pend_ff & ~(16'd1 << pick);
      end
   end

   always_ff @(posedge clock) begin
      map_ff   <= map_in;
      cidx_ff  <= cidx_in;
      cov_ff   <= cov_in;
      multi_ff <= multi_in;
      ngrp_ff  <= ngrp_in;
      pend_ff  <= pend_in;
   end

   // Group store, written at the next free entry.
   always_ff @(posedge clock) begin
      if (take) begin
         gmask_ff[ngrp_ff[3:0]] <= cand.mask;
         glit_ff[ngrp_ff[3:0]]  <= {cand.lit_a, cand.lit_b, cand.lit_c, cand.lit_d};
      end
   end

   // Result register: one term per emit command.
   always_comb begin
      valid_in = cmd.emit_term || cmd.emit_const;
      lits_in  = lits_ff;
      none_in  = none_ff;
      last_in  = last_ff;
      if (cmd.emit_term) begin
         lits_in = glit_ff[pick];
         none_in = 1'b0;
         last_in = status.pend_single;
      end else if (cmd.emit_const) begin
         lits_in = {kmap_pkg::LIT_ABSENT, kmap_pkg::LIT_ABSENT,
                    kmap_pkg::LIT_ABSENT, kmap_pkg::LIT_ABSENT};
         none_in = !status.map_full;
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      lits_ff <= lits_in;
      none_ff <= none_in;
      last_ff <= last_in;
   end

   // Status to the controller.
   assign status.map_full    = (map_ff == 16'hFFFF);
   assign status.map_zero    = (map_ff == 16'h0000);
   assign status.cand_last   = (cidx_ff == 7'(kmap_pkg::CAND_COUNT - 1));
   assign status.pend_empty  = (pend_ff == 16'd0);
   assign status.pend_single = (pend_ff != 16'd0) &&
                               ((pend_ff & (pend_ff - 16'd1)) == 16'd0);

   assign rsp_valid     = valid_ff;
   assign rsp_lit_a     = lits_ff[7:6];
   assign rsp_lit_b     = lits_ff[5:4];
   assign rsp_lit_c     = lits_ff[3:2];
   assign rsp_lit_d     = lits_ff[1:0];
   assign rsp_no_terms  = none_ff;
   assign rsp_last_term = last_ff;

endmodule

[hdl/kmap4_greedy_sop_minimizer_core.sv]
// Four-variable Karnaugh map minimizer with a greedy cover.
// Request channel: a map is accepted on a clock edge where start is high and
// busy is low; req_cell_map holds the 16 cells, bit 4*row+col, rows and
// columns in Gray order. Busy stays high until the last term of the map has
// been launched.
// Response channel: each product term appears on the rsp_ ports for exactly
// one cycle with rsp_valid high; rsp_last_term marks the final term of a map.
// An all-zero map gives one transaction with rsp_no_terms set; an all-ones
// map gives one transaction with every literal absent.
// A constant map is answered from the sweep state without a candidate walk.
// Any other map walks all 104 candidate groups, one per cycle through the
// single coverage test, then marks kept groups in the mark state, then
// emits one term per cycle from the emit state. Each term passes through
// the result register before it appears on the rsp_ ports. The next map
// can be accepted on the cycle after the last term is launched.
// Reset returns the controller to idle and drops any pending transaction.
// The receiver cannot stall; every response is taken in its one cycle.
module kmap4_greedy_sop_minimizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_cell_map,
   output logic        rsp_valid,
   output logic [1:0]  rsp_lit_a,
   output logic [1:0]  rsp_lit_b,
   output logic [1:0]  rsp_lit_c,
   output logic [1:0]  rsp_lit_d,
   output logic        rsp_no_terms,
   output logic        rsp_last_term
);

   kmap_pkg::cmd_type    cmd;
   kmap_pkg::status_type status;

   // Sequencer for sweep, mark and emit phases.
   kmap_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Coverage counts, group store and result register.
   kmap_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_cell_map  (req_cell_map),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_lit_a     (rsp_lit_a),
      .rsp_lit_b     (rsp_lit_b),
      .rsp_lit_c     (rsp_lit_c),
      .rsp_lit_d     (rsp_lit_d),
      .rsp_no_terms  (rsp_no_terms),
      .rsp_last_term (rsp_last_term)
   );

endmodule
